FILE: hw/rtl/tagged_next_block_prefetcher_core_defines.svh
// Assertion macros shared by the prefetcher's checker.
`ifndef TAGGED_NEXT_BLOCK_PREFETCHER_CORE_DEFINES_SVH
`define TAGGED_NEXT_BLOCK_PREFETCHER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TNBP_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tnbp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TNBP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tnbp assertion failed");

// Next-cycle implication that is checked across reset as well.
`define TNBP_ASSERT_RST(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tnbp reset assertion failed");

`endif

FILE: hw/rtl/tnbp_pkg.sv
// Types and constants of the tagged next-block prefetcher.
package tnbp_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned BS_W       = 13;
  localparam int unsigned RPT_W      = 5;
  localparam int unsigned REM_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // Input function codes
  localparam logic FUNC_ACCESS   = 1'b0;
  localparam logic FUNC_COMPLETE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REQS_PER_TRG = 2'd1;

  localparam logic [BS_W-1:0]  BLOCK_SIZE_RST = 13'd32;
  localparam logic [RPT_W-1:0] REQS_RST       = 5'd2;
  localparam logic [RPT_W-1:0] REQS_MAX       = 5'd16;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] access_addr;
    logic              hit_l1;
  } in_t;

  typedef struct packed {
    logic              request_valid;
    logic [ADDR_W-1:0] request_addr;
  } out_t;

endpackage

FILE: hw/rtl/tagged_next_block_prefetcher_core.sv
// Tagged next-block prefetcher: top level.
//
// Usage: CPU accesses (func = access) and prefetch completions (func =
// complete) arrive on the in_ channel, one transaction per cycle at most.
// Every accepted transaction yields exactly one out_ transaction holding
// the pending prefetch request (request_valid, request_addr; addr 0 when idle).
// block_size and requests_per_trigger are written on the cfg_ channel,
// which is always ready; write it only while the block is idle.
// Path: an accepted input passes the input register, then the tag lookup/update
// logic into the result register. Throughput: one transaction per cycle when
// not stalled or clearing; the tag memory has one write port and takes one
// write per cycle, a second tag update is held in a one-entry write buffer.
// Reset: rst_n is synchronous; afterwards a clearing pass writes every tag
// entry, with in_ready low (cfg writes still taken).
// Stall: when out_ready is low the result register holds, the input register
// fills, and in_ready drops until the result is taken.
// TAG_ENTRIES must be a power of two; the tag index is the low address bits.
module tagged_next_block_prefetcher_core #(
  parameter int unsigned TAG_ENTRIES = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  tnbp_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output tnbp_pkg::out_t                       out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tnbp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tnbp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import tnbp_pkg::*;

  localparam int unsigned IDX_W = $clog2(TAG_ENTRIES);

  // configuration
  logic [BS_W-1:0]  block_size_r;
  logic [RPT_W-1:0] reqs_r;

  // prefetch run state
  logic              pending_r, pending_nxt;
  logic [ADDR_W-1:0] next_addr_r, next_addr_nxt;
  logic [REM_W-1:0]  remaining_r, remaining_nxt;

  // pipeline
  logic  s1_valid_r;
  in_t   s1_data_r;
  logic  out_valid_r;
  out_t  out_data_r, out_data_nxt;

  // clearing pass
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_cnt_r;

  // deferred tag set and last write, for forwarding
  logic             buf_valid_r, buf_valid_nxt;
  logic [IDX_W-1:0] buf_idx_r, buf_idx_nxt;
  logic             wrp_valid_r;
  logic [IDX_W-1:0] wrp_idx_r;
  logic             wrp_data_r;

  // tag memory port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_rdata;

  logic              proc, in_acc;
  logic [IDX_W-1:0]  a_idx, set_idx;
  logic              tag_hit;
  logic              is_access, start, start_tag, adv, end_run;
  logic              set_op, buf_set;
  logic [ADDR_W-1:0] sum_base, sum;
  logic [REM_W-1:0]  run_m1;

  assign cfg_ready = 1'b1;
  assign proc      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !clr_busy_r && (!s1_valid_r || proc);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // keep re-reading the held entry so a stalled item sees later writes
  assign a_idx     = s1_data_r.access_addr[IDX_W-1:0];
  assign mem_raddr = in_acc ? in_data.access_addr[IDX_W-1:0] : a_idx;

  tnbp_tag_mem #(
    .DEPTH (TAG_ENTRIES)
  ) u_tag_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // buffered set is newest, then the previous edge's write, then the array
  always_comb begin
    if (buf_valid_r && buf_idx_r == a_idx) begin
      tag_hit = 1'b1;
    end else if (wrp_valid_r && wrp_idx_r == a_idx) begin
      tag_hit = wrp_data_r;
    end else begin
      tag_hit = mem_rdata;
    end
  end

  // run length minus one, with the count clamped to 1..16
  always_comb begin
    if (reqs_r == '0) begin
      run_m1 = '0;
    end else if (reqs_r >= REQS_MAX) begin
      run_m1 = '1;
    end else begin
      run_m1 = REM_W'(reqs_r - 1'b1);
    end
  end

  assign is_access = (s1_data_r.func == FUNC_ACCESS);
  assign sum_base  = is_access ? s1_data_r.access_addr : next_addr_r;
  assign sum       = sum_base + ADDR_W'(block_size_r);
  assign set_idx   = sum[IDX_W-1:0];

  assign start     = is_access && !pending_r && (!s1_data_r.hit_l1 || tag_hit);
  assign start_tag = start && s1_data_r.hit_l1;
  assign adv       = !is_access && pending_r && (remaining_r != '0);
  assign end_run   = !is_access && pending_r && (remaining_r == '0);
  // on a start the later clear of the accessed entry wins
  assign buf_set   = start_tag && (set_idx != a_idx);
  assign set_op    = adv;

  always_comb begin
    pending_nxt   = pending_r;
    next_addr_nxt = next_addr_r;
    remaining_nxt = remaining_r;
    if (proc) begin
      if (start) begin
        pending_nxt   = 1'b1;
        next_addr_nxt = sum;
        remaining_nxt = run_m1;
      end else if (adv) begin
        next_addr_nxt = sum;
        remaining_nxt = remaining_r - 1'b1;
      end else if (end_run) begin
        pending_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_data_nxt.request_valid = pending_nxt;
    out_data_nxt.request_addr  = pending_nxt ? next_addr_nxt : '0;
  end

  // tag write port arbitration
  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = a_idx;
    mem_wdata     = 1'b0;
    buf_valid_nxt = buf_valid_r;
    buf_idx_nxt   = buf_idx_r;
    if (clr_busy_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = 1'b0;
    end else if (proc && is_access) begin
      mem_we    = 1'b1;
      mem_waddr = a_idx;
      mem_wdata = 1'b0;
      if (buf_set) begin
        buf_valid_nxt = 1'b1;
        buf_idx_nxt   = set_idx;
      end else if (buf_valid_r && buf_idx_r == a_idx) begin
        buf_valid_nxt = 1'b0;
      end
    end else if (proc && set_op) begin
      mem_we    = 1'b1;
      mem_waddr = set_idx;
      mem_wdata = 1'b1;
    end else if (buf_valid_r) begin
      // free slot: drain the deferred set
      mem_we        = 1'b1;
      mem_waddr     = buf_idx_r;
      mem_wdata     = 1'b1;
      buf_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BLOCK_SIZE_RST;
      reqs_r       <= REQS_RST;
      pending_r    <= 1'b0;
      next_addr_r  <= '0;
      remaining_r  <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      clr_busy_r   <= 1'b1;
      clr_cnt_r    <= '0;
      buf_valid_r  <= 1'b0;
      wrp_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_BLOCK_SIZE:   block_size_r <= cfg_data[BS_W-1:0];
          REG_REQS_PER_TRG: reqs_r       <= cfg_data[RPT_W-1:0];
          default:          ;
        endcase
      end
      pending_r   <= pending_nxt;
      next_addr_r <= next_addr_nxt;
      remaining_r <= remaining_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (proc) begin
        s1_valid_r <= 1'b0;
      end
      if (proc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          clr_busy_r <= 1'b0;
        end
      end
      buf_valid_r <= buf_valid_nxt;
      wrp_valid_r <= mem_we;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    if (proc) begin
      out_data_r <= out_data_nxt;
    end
    buf_idx_r  <= buf_idx_nxt;
    wrp_idx_r  <= mem_waddr;
    wrp_data_r <= mem_wdata;
  end

endmodule

FILE: hw/rtl/tnbp_tag_mem.sv
// Tag bit memory: one write port, one read port with registered data.
module tnbp_tag_mem #(
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];
  logic rdata_r;

  // read returns the contents from before a write at the same edge
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/tnbp_checker.sv
// Port-level checker for the prefetcher, bound to the top level.
`include "tagged_next_block_prefetcher_core_defines.svh"

module tnbp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input tnbp_pkg::out_t out_data
);

  import tnbp_pkg::*;

  // a held result keeps its payload
  `TNBP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // no request pending means a zero address
  `TNBP_ASSERT_NOW(a_idle_addr, clk, rst_n, out_valid && !out_data.request_valid, out_data.request_addr == '0)

  // an accepted transaction reaches the output once the receiver is ready
  `TNBP_ASSERT_NXT(a_fwd, clk, rst_n, $past(in_valid && in_ready) && out_ready, out_valid)

  // nothing leaves right after reset, and the clearing pass blocks input
  `TNBP_ASSERT_RST(a_rst, clk, !rst_n, !out_valid && !in_ready)

endmodule

bind tagged_next_block_prefetcher_core tnbp_checker u_tnbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
